### design/srtf_pkg.sv
// Package with shared constants, widths and types of the SRTF scheduler.
package srtf_pkg;

    localparam int MAX_PROCS = 16;
    localparam int IDX_W     = $clog2(MAX_PROCS);
    localparam int CNT_W     = IDX_W + 1;
    localparam int SLOT_W    = 4;
    localparam int TIME_W    = 24;
    localparam int BURST_W   = 16;

    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    typedef enum logic {
        CMD_LOAD = 1'b0,
        CMD_TICK = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_UPDATE
    } t_state;

endpackage

### design/srtf_if.sv
// Request and result channel interfaces of the SRTF scheduler.
interface srtf_in_if
    import srtf_pkg::*;
;
    logic               valid;
    logic               ready;
    logic               command;
    logic [SLOT_W-1:0]  slot;
    logic [TIME_W-1:0]  arrival_time;
    logic [BURST_W-1:0] burst_time;

    modport source (output valid, command, slot, arrival_time, burst_time, input ready);
    modport sink   (input valid, command, slot, arrival_time, burst_time, output ready);
endinterface

interface srtf_out_if
    import srtf_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [TIME_W-1:0] time_end;
    logic              busy_res;
    logic [SLOT_W-1:0] ran_slot;
    logic              completed;
    logic [TIME_W-1:0] turnaround;
    logic [TIME_W-1:0] waiting;
    logic              all_done;

    modport source (output valid, time_end, busy_res, ran_slot, completed, turnaround,
                    waiting, all_done, input ready);
    modport sink   (input valid, time_end, busy_res, ran_slot, completed, turnaround,
                    waiting, all_done, output ready);
endinterface

### design/srtf_process_scheduler_top.sv
// Top level of the shortest-remaining-time-first process scheduler.
//
//   channel  | dir | carries
//   ---------+-----+------------------------------------------------------
//   i_req    | in  | command, slot, arrival_time, burst_time
//   o_res    | out | time_end, busy_res, ran_slot, completed, turnaround,
//            |     | waiting, all_done (one result per tick request)
//
// A load request is written into the slot table when it is accepted. A tick request
// is accepted in the idle state, streams the slot table through the single compare
// unit in the scan state, and updates the chosen slot in the update state.
// The scan is serial because the slot table has one read port.
// Reset clears time and the loaded and finished flags at once.
// A result waits in the output register; the next request may start meanwhile
// and a tick stalls only in its update cycle until that register is free.
module srtf_process_scheduler_top
    import srtf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    srtf_in_if.sink    i_req,
    srtf_out_if.source o_res
);

    t_state r_state, n_state;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [TIME_W-1:0]  r_time, n_time;
    logic [MAX_PROCS-1:0] r_loaded, n_loaded;
    logic [MAX_PROCS-1:0] r_fin, n_fin;

    logic [TIME_W-1:0]  r_mem_arr [MAX_PROCS];
    logic [BURST_W-1:0] r_mem_bur [MAX_PROCS];
    logic [BURST_W-1:0] r_mem_rem [MAX_PROCS];
    logic [TIME_W-1:0]  r_rd_arr;
    logic [BURST_W-1:0] r_rd_bur;
    logic [BURST_W-1:0] r_rd_rem;

    logic               r_found, n_found;
    logic [IDX_W-1:0]   r_best, n_best;
    logic [TIME_W-1:0]  r_best_arr, n_best_arr;
    logic [BURST_W-1:0] r_best_bur, n_best_bur;
    logic [BURST_W-1:0] r_best_rem, n_best_rem;

    logic               r_out_valid, n_out_valid;
    logic [TIME_W-1:0]  r_o_time, n_o_time;
    logic               r_o_busy, n_o_busy;
    logic [SLOT_W-1:0]  r_o_slot, n_o_slot;
    logic               r_o_done, n_o_done;
    logic [TIME_W-1:0]  r_o_tat, n_o_tat;
    logic [TIME_W-1:0]  r_o_wt, n_o_wt;
    logic               r_o_all, n_o_all;

    logic               wr_load;
    logic               wr_rem;
    logic [IDX_W-1:0]   wr_idx;
    logic [BURST_W-1:0] wr_rem_val;
    logic [IDX_W-1:0]   rd_idx;
    logic [IDX_W-1:0]   cmp_idx;
    logic               cmp_ok;
    logic               cmp_wins;
    logic [TIME_W-1:0]  t_end;
    logic [BURST_W-1:0] rem_dec;
    logic [TIME_W-1:0]  tat;
    logic [TIME_W-1:0]  bur_ext;
    logic               in_fire;
    logic               out_fire;
    logic               slot_in_range;

    assign in_fire   = i_req.valid && i_req.ready;
    assign out_fire  = r_out_valid && o_res.ready;
    assign i_req.ready = (r_state == S_IDLE);

    assign slot_in_range = ({{(CNT_W){1'b0}}, i_req.slot} < (CNT_W + SLOT_W)'(MAX_PROCS));
    assign rd_idx  = r_cnt[IDX_W-1:0];
    assign cmp_idx = r_cnt[IDX_W-1:0] - IDX_W'(1);
    assign cmp_ok  = r_loaded[cmp_idx] && !r_fin[cmp_idx] && (r_rd_arr <= r_time);
    assign cmp_wins = !r_found || (r_rd_rem < r_best_rem) ||
                      ((r_rd_rem == r_best_rem) && (r_rd_arr < r_best_arr));
    assign t_end   = (r_time == TIME_MAX) ? TIME_MAX : r_time + TIME_W'(1);
    assign rem_dec = r_best_rem - BURST_W'(1);
    assign tat     = t_end - r_best_arr;
    assign bur_ext = TIME_W'(r_best_bur);

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_time      = r_time;
        n_loaded    = r_loaded;
        n_fin       = r_fin;
        n_found     = r_found;
        n_best      = r_best;
        n_best_arr  = r_best_arr;
        n_best_bur  = r_best_bur;
        n_best_rem  = r_best_rem;
        n_out_valid = r_out_valid && !out_fire;
        n_o_time    = r_o_time;
        n_o_busy    = r_o_busy;
        n_o_slot    = r_o_slot;
        n_o_done    = r_o_done;
        n_o_tat     = r_o_tat;
        n_o_wt      = r_o_wt;
        n_o_all     = r_o_all;
        wr_load     = 1'b0;
        wr_rem      = 1'b0;
        wr_idx      = r_best;
        wr_rem_val  = rem_dec;
        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    if (i_req.command == CMD_TICK) begin
                        n_state = S_SCAN;
                        n_cnt   = '0;
                        n_found = 1'b0;
                        n_best  = '0;
                    end else if (slot_in_range) begin
                        wr_load    = 1'b1;
                        wr_idx     = IDX_W'(i_req.slot);
                        wr_rem_val = i_req.burst_time;
                        n_loaded[IDX_W'(i_req.slot)] = 1'b1;
                        n_fin[IDX_W'(i_req.slot)]    = (i_req.burst_time == '0);
                    end
                end
            end
            S_SCAN: begin
                if (r_cnt != '0 && cmp_ok && cmp_wins) begin
                    n_found    = 1'b1;
                    n_best     = cmp_idx;
                    n_best_arr = r_rd_arr;
                    n_best_bur = r_rd_bur;
                    n_best_rem = r_rd_rem;
                end
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(MAX_PROCS)) begin
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: begin
                if (!r_out_valid || o_res.ready) begin
                    n_state     = S_IDLE;
                    n_time      = t_end;
                    n_out_valid = 1'b1;
                    n_o_time    = t_end;
                    n_o_busy    = r_found;
                    n_o_slot    = r_found ? SLOT_W'(r_best) : '0;
                    n_o_done    = 1'b0;
                    n_o_tat     = '0;
                    n_o_wt      = '0;
                    if (r_found) begin
                        wr_rem = 1'b1;
                        if (rem_dec == '0) begin
                            n_fin[r_best] = 1'b1;
                            n_o_done      = 1'b1;
                            n_o_tat       = tat;
                            n_o_wt        = (tat >= bur_ext) ? tat - bur_ext : '0;
                        end
                    end
                    n_o_all = &(~r_loaded | n_fin);
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_time      <= '0;
            r_loaded    <= '0;
            r_fin       <= '0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_time      <= n_time;
            r_loaded    <= n_loaded;
            r_fin       <= n_fin;
            r_found     <= n_found;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_best     <= n_best;
        r_best_arr <= n_best_arr;
        r_best_bur <= n_best_bur;
        r_best_rem <= n_best_rem;
        r_o_time   <= n_o_time;
        r_o_busy   <= n_o_busy;
        r_o_slot   <= n_o_slot;
        r_o_done   <= n_o_done;
        r_o_tat    <= n_o_tat;
        r_o_wt     <= n_o_wt;
        r_o_all    <= n_o_all;
    end

    always_ff @(posedge i_clk) begin
        if (wr_load) begin
            r_mem_arr[wr_idx] <= i_req.arrival_time;
            r_mem_bur[wr_idx] <= i_req.burst_time;
        end
        if (wr_load || wr_rem) begin
            r_mem_rem[wr_idx] <= wr_rem_val;
        end
        r_rd_arr <= r_mem_arr[rd_idx];
        r_rd_bur <= r_mem_bur[rd_idx];
        r_rd_rem <= r_mem_rem[rd_idx];
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.time_end   = r_o_time;
    assign o_res.busy_res   = r_o_busy;
    assign o_res.ran_slot   = r_o_slot;
    assign o_res.completed  = r_o_done;
    assign o_res.turnaround = r_o_tat;
    assign o_res.waiting    = r_o_wt;
    assign o_res.all_done   = r_o_all;

    a_ready_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.ready |-> (r_state == S_IDLE))
        else $error("Request accepted outside the idle state.");

    a_best_is_runnable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPDATE && r_found) |-> (r_loaded[r_best] && !r_fin[r_best]))
        else $error("Chosen slot is not loaded or already finished.");

    a_result_from_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_UPDATE))
        else $error("Result raised outside the update cycle.");

    a_scan_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && r_cnt == CNT_W'(MAX_PROCS)) |=> (r_state == S_UPDATE))
        else $error("Scan did not end in the update cycle.");

endmodule

### sim/testbench.sv
// Self-checking testbench of the SRTF process scheduler: directed table, then random requests.
module testbench;
    import srtf_pkg::*;

    localparam int DIR_ROWS     = 24;
    localparam int RAND_ITEMS   = 410;
    localparam int QUIET_AFTER  = 360;
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 40;

    typedef struct packed {
        logic [TIME_W-1:0] time_end;
        logic              busy;
        logic [SLOT_W-1:0] slot;
        logic              completed;
        logic [TIME_W-1:0] turnaround;
        logic [TIME_W-1:0] waiting;
        logic              all_done;
    } t_tick_result;

    typedef struct packed {
        t_cmd               cmd;
        logic [SLOT_W-1:0]  slot;
        logic [TIME_W-1:0]  arrival;
        logic [BURST_W-1:0] burst;
        logic               typed;
        t_tick_result       want;
    } t_dir_row;

    localparam t_tick_result NO_RESULT = '0;

    t_dir_row dir_rows [DIR_ROWS] = '{
        '{CMD_TICK, 4'd15, 24'hFFFFFF, 16'hFFFF, 1'b1, '{24'd1, 1'b0, 4'd0, 1'b0, 24'd0, 24'd0, 1'b1}},
        '{CMD_LOAD, 4'd15, 24'hFFFFFF, 16'hFFFF, 1'b0, NO_RESULT},
        '{CMD_TICK, 4'd0,  24'd0,      16'd0,    1'b1, '{24'd2, 1'b0, 4'd0, 1'b0, 24'd0, 24'd0, 1'b0}},
        '{CMD_LOAD, 4'd0,  24'd0,      16'd1,    1'b0, NO_RESULT},
        '{CMD_TICK, 4'd9,  24'h123456, 16'h8001, 1'b1, '{24'd3, 1'b1, 4'd0, 1'b1, 24'd3, 24'd2, 1'b0}},
        '{CMD_LOAD, 4'd3,  24'd0,      16'd0,    1'b0, NO_RESULT},
        '{CMD_TICK, 4'd0,  24'd0,      16'd0,    1'b1, '{24'd4, 1'b0, 4'd0, 1'b0, 24'd0, 24'd0, 1'b0}},
        '{CMD_LOAD, 4'd5,  24'd2,      16'd3,    1'b0, NO_RESULT},
        '{CMD_LOAD, 4'd7,  24'd4,      16'd3,    1'b0, NO_RESULT},
        '{CMD_LOAD, 4'd6,  24'd4,      16'd3,    1'b0, NO_RESULT},
        '{CMD_TICK, 4'd0,  24'd0,      16'd0,    1'b0, NO_RESULT},
        '{CMD_TICK, 4'd0,  24'd0,      16'd0,    1'b0, NO_RESULT},
        '{CMD_LOAD, 4'd2,  24'd5,      16'd1,    1'b0, NO_RESULT},
        '{CMD_TICK, 4'd0,  24'd0,      16'd0,    1'b0, NO_RESULT},
        '{CMD_TICK, 4'd0,  24'd0,      16'd0,    1'b0, NO_RESULT},
        '{CMD_LOAD, 4'd5,  24'd0,      16'd2,    1'b0, NO_RESULT},
        '{CMD_TICK, 4'd0,  24'd0,      16'd0,    1'b0, NO_RESULT},
        '{CMD_TICK, 4'd0,  24'd0,      16'd0,    1'b0, NO_RESULT},
        '{CMD_TICK, 4'd0,  24'd0,      16'd0,    1'b0, NO_RESULT},
        '{CMD_TICK, 4'd0,  24'd0,      16'd0,    1'b0, NO_RESULT},
        '{CMD_LOAD, 4'd15, 24'd0,      16'd1,    1'b0, NO_RESULT},
        '{CMD_TICK, 4'd0,  24'd0,      16'd0,    1'b0, NO_RESULT},
        '{CMD_TICK, 4'd0,  24'd0,      16'd0,    1'b0, NO_RESULT},
        '{CMD_TICK, 4'd0,  24'd0,      16'd0,    1'b0, NO_RESULT}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    srtf_in_if  req_ch ();
    srtf_out_if res_ch ();

    srtf_process_scheduler_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_res   (res_ch.source)
    );

    // Scheduler state as the checker sees it.
    logic [TIME_W-1:0]  sched_time;
    logic               slot_used  [MAX_PROCS];
    logic               slot_done  [MAX_PROCS];
    logic [TIME_W-1:0]  arrival_tab[MAX_PROCS];
    logic [BURST_W-1:0] burst_tab  [MAX_PROCS];
    logic [BURST_W-1:0] remain_tab [MAX_PROCS];

    t_tick_result expected_ticks [$];
    t_tick_result predicted;
    t_tick_result oldest;
    logic         req_typed;
    t_tick_result req_typed_result;

    int  mismatches    = 0;
    int  idle_cycles   = 0;
    int  tick_count    = 0;
    int  requests_sent = 0;
    int  ready_hold    = 0;
    bit  quiet         = 1'b0;
    logic res_ready_next;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic void record_load(logic [SLOT_W-1:0] s, logic [TIME_W-1:0] a,
                                        logic [BURST_W-1:0] b);
        slot_used[s]   = 1'b1;
        slot_done[s]   = (b == '0);
        arrival_tab[s] = a;
        burst_tab[s]   = b;
        remain_tab[s]  = b;
    endfunction

    function automatic t_tick_result predict_tick();
        t_tick_result r;
        int           best;
        bit           found;
        r     = '0;
        best  = 0;
        found = 1'b0;
        for (int i = 0; i < MAX_PROCS; i++) begin
            if (slot_used[i] && !slot_done[i] && arrival_tab[i] <= sched_time) begin
                if (!found || remain_tab[i] < remain_tab[best] ||
                    (remain_tab[i] == remain_tab[best] && arrival_tab[i] < arrival_tab[best])) begin
                    best  = i;
                    found = 1'b1;
                end
            end
        end
        r.time_end = (sched_time == TIME_MAX) ? TIME_MAX : sched_time + 1'b1;
        if (found) begin
            r.busy = 1'b1;
            r.slot = best[SLOT_W-1:0];
            remain_tab[best] = remain_tab[best] - 1'b1;
            if (remain_tab[best] == '0) begin
                slot_done[best] = 1'b1;
                r.completed     = 1'b1;
                r.turnaround    = r.time_end - arrival_tab[best];
                r.waiting       = (r.turnaround >= burst_tab[best]) ?
                                  r.turnaround - burst_tab[best] : '0;
            end
        end
        sched_time = r.time_end;
        r.all_done = 1'b1;
        for (int i = 0; i < MAX_PROCS; i++)
            if (slot_used[i] && !slot_done[i])
                r.all_done = 1'b0;
        return r;
    endfunction

    task automatic check_field(string name, logic [TIME_W-1:0] want, logic [TIME_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    // Results are checked before the request of the same edge is predicted.
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1) begin
            if (res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
                if (expected_ticks.size() == 0) begin
                    $display("%0t: result expected none actual time_end %0h", $time,
                             res_ch.time_end);
                    mismatches++;
                end else begin
                    oldest = expected_ticks.pop_front();
                    check_field("time_end",   oldest.time_end,   res_ch.time_end);
                    check_field("busy_res",   TIME_W'(oldest.busy),
                                TIME_W'(res_ch.busy_res));
                    check_field("ran_slot",   TIME_W'(oldest.slot),
                                TIME_W'(res_ch.ran_slot));
                    check_field("completed",  TIME_W'(oldest.completed),
                                TIME_W'(res_ch.completed));
                    check_field("turnaround", oldest.turnaround, res_ch.turnaround);
                    check_field("waiting",    oldest.waiting,    res_ch.waiting);
                    check_field("all_done",   TIME_W'(oldest.all_done),
                                TIME_W'(res_ch.all_done));
                end
            end
            if (req_ch.valid === 1'b1 && req_ch.ready === 1'b1) begin
                if (req_ch.command == CMD_LOAD) begin
                    record_load(req_ch.slot, req_ch.arrival_time, req_ch.burst_time);
                end else begin
                    predicted = predict_tick();
                    expected_ticks.insert(expected_ticks.size(),
                                          req_typed ? req_typed_result : predicted);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
            (res_ch.valid === 1'b1 && res_ch.ready === 1'b1)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        if (quiet) begin
            res_ready_next = 1'b1;
        end else if (ready_hold > 0) begin
            res_ready_next = 1'b0;
            ready_hold--;
        end else begin
            res_ready_next = 1'b1;
            if ($urandom_range(0, 7) == 0)
                ready_hold = $urandom_range(1, 9);
        end
        res_ch.ready <= res_ready_next;
    end

    task automatic send_request(t_cmd cmd, logic [SLOT_W-1:0] s, logic [TIME_W-1:0] a,
                                logic [BURST_W-1:0] b, logic typed, t_tick_result want);
        int gap;
        if (!quiet && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 9);
            @(negedge i_clk);
            req_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        req_ch.valid        <= 1'b1;
        req_ch.command      <= cmd;
        req_ch.slot         <= s;
        req_ch.arrival_time <= a;
        req_ch.burst_time   <= b;
        req_typed            = typed;
        req_typed_result     = want;
        if (cmd == CMD_TICK)
            tick_count++;
        requests_sent++;
        do @(posedge i_clk); while (req_ch.ready !== 1'b1);
    endtask

    task automatic pause_until_drained();
        @(negedge i_clk);
        req_ch.valid <= 1'b0;
        while (expected_ticks.size() != 0) @(negedge i_clk);
    endtask

    function automatic logic [TIME_W-1:0] near_arrival();
        int d;
        d = tick_count + $urandom_range(0, 8) - 3;
        return (d < 0) ? '0 : d[TIME_W-1:0];
    endfunction

    task automatic random_tick();
        send_request(CMD_TICK, SLOT_W'($urandom), TIME_W'($urandom), BURST_W'($urandom),
                     1'b0, NO_RESULT);
    endtask

    initial begin
        int episode;
        int n_loads;
        int work;
        int n_ticks;
        logic [BURST_W-1:0] b;

        i_rst_n             = 1'b0;
        req_ch.valid        = 1'b0;
        req_ch.command      = CMD_LOAD;
        req_ch.slot         = '0;
        req_ch.arrival_time = '0;
        req_ch.burst_time   = '0;
        res_ch.ready        = 1'b0;
        req_typed           = 1'b0;
        req_typed_result    = '0;
        sched_time          = '0;
        for (int i = 0; i < MAX_PROCS; i++) begin
            slot_used[i] = 1'b0;
            slot_done[i] = 1'b0;
        end
        episode = 0;

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < DIR_ROWS; r++)
            send_request(dir_rows[r].cmd, dir_rows[r].slot, dir_rows[r].arrival,
                         dir_rows[r].burst, dir_rows[r].typed, dir_rows[r].want);
        pause_until_drained();

        // Mostly batches of short processes ticked to completion, with stray requests mixed in.
        while (requests_sent < DIR_ROWS + RAND_ITEMS) begin
            episode++;
            if (requests_sent >= DIR_ROWS + QUIET_AFTER)
                quiet = 1'b1;
            if (episode % 6 == 0) begin
                for (int s = 0; s < MAX_PROCS; s++)
                    send_request(CMD_LOAD, SLOT_W'(s), TIME_W'($urandom), '0, 1'b0,
                                 NO_RESULT);
                random_tick();
            end else begin
                n_loads = $urandom_range(1, 5);
                work    = 0;
                for (int k = 0; k < n_loads; k++) begin
                    b = ($urandom_range(0, 7) == 0) ? BURST_W'($urandom_range(1, 65535)) :
                                                      BURST_W'($urandom_range(1, 6));
                    send_request(CMD_LOAD, SLOT_W'($urandom), near_arrival(), b, 1'b0,
                                 NO_RESULT);
                    work += (b > 8) ? 8 : b;
                end
                n_ticks = work + $urandom_range(0, 3);
                for (int k = 0; k < n_ticks; k++) begin
                    if ($urandom_range(0, 9) == 0)
                        send_request(CMD_LOAD, SLOT_W'($urandom),
                                     $urandom_range(0, 1) ? near_arrival() :
                                                            TIME_W'($urandom),
                                     BURST_W'($urandom), 1'b0, NO_RESULT);
                    else
                        random_tick();
                end
            end
            if (episode == 10)
                pause_until_drained();
        end

        @(negedge i_clk);
        req_ch.valid <= 1'b0;
        while (expected_ticks.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && expected_ticks.size() == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule
